FILE: hdl/srtp_replay_window_check_assert.svh
// ----------------------------------------------------------------------------
// srtp replay window check assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SRTP_REPLAY_WINDOW_CHECK_ASSERT_SVH
`define SRTP_REPLAY_WINDOW_CHECK_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRTP_RWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SRTP_RWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/srtp_rwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp replay window check package
// widths, register indexes, operation codes and defaults
// ----------------------------------------------------------------------------
package srtp_rwc_pkg;

    localparam int SEQ_W               = 16;
    localparam int ROC_W               = 32;
    localparam int INDEX_W             = ROC_W + SEQ_W;
    localparam int DIFF_W              = SEQ_W + 2;
    localparam int HALF_SEQ            = 32768;
    localparam int SEQ_SPAN            = 65536;
    localparam int DEFAULT_WINDOW_SIZE = 128;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = ROC_W;

    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ROC        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTECTION_ENABLED = 1'd1;

    localparam logic OP_UPDATE = 1'b1;

endpackage

FILE: hdl/srtp_rwc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp replay window check channels
// valid/ready interfaces for the sequence beat and the result beat
// ----------------------------------------------------------------------------
interface srtp_rwc_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [srtp_rwc_pkg::SEQ_W-1:0]   seq_number;

    modport source (output valid, operation, seq_number, input ready);
    modport sink   (input valid, operation, seq_number, output ready);
endinterface

interface srtp_rwc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             accept;
    logic [srtp_rwc_pkg::INDEX_W-1:0] packet_index;

    modport source (output valid, accept, packet_index, input ready);
    modport sink   (input valid, accept, packet_index, output ready);
endinterface

FILE: hdl/srtp_replay_window_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp replay window check
// rfc 3711 packet index estimation with a sliding replay bitmap
// ----------------------------------------------------------------------------
// Takes one sequence beat per clock, bounded by the state update that each
// beat depends on, unless a stalled result holds the input register, and
// returns one result beat for each. The beat is captured in the input
// register, then the index guess, the replay lookup and the window update
// (bitmap shift or mark, highest sequence, rollover counter) all complete as
// the beat leaves that register, while the result register is loaded. The
// result register lets a new beat enter while a finished result waits.
// Register writes (index 0 initial rollover counter, also loaded into the
// live counter; index 1 protection enable) must be issued only while no beat
// is in flight.
// ----------------------------------------------------------------------------
module srtp_replay_window_check #(
    parameter int WINDOW_SIZE = srtp_rwc_pkg::DEFAULT_WINDOW_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [srtp_rwc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srtp_rwc_pkg::CFG_DATA_W-1:0]  cfg_data,
    srtp_rwc_in_if.sink                         in_ch,
    srtp_rwc_out_if.source                      out_ch
);

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int SEQ_W = srtp_rwc_pkg::SEQ_W;
    localparam int ROC_W = srtp_rwc_pkg::ROC_W;
    localparam int DIFF_W = srtp_rwc_pkg::DIFF_W;
    localparam logic [WINDOW_SIZE-1:0] BIT0 = WINDOW_SIZE'(1);

    // configuration
    logic                      protection_enabled_reg;

    // window state
    logic [ROC_W-1:0]          rollover_count_reg;
    logic [ROC_W-1:0]          rollover_count_next;
    logic [SEQ_W-1:0]          highest_seq_reg;
    logic [SEQ_W-1:0]          highest_seq_next;
    logic                      seq_seen_reg;
    logic [WINDOW_SIZE-1:0]    replay_bitmap_reg;
    logic [WINDOW_SIZE-1:0]    replay_bitmap_next;

    // input register
    logic                      in_valid_reg;
    logic                      in_op_reg;
    logic [SEQ_W-1:0]          in_seq_reg;

    // result register
    logic                      out_valid_reg;
    logic                      out_accept_reg;
    logic [srtp_rwc_pkg::INDEX_W-1:0] out_index_reg;

    logic                      work_fire;
    logic [SEQ_W-1:0]          hs_eff;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  delta;
    logic signed [DIFF_W-1:0]  neg_delta;
    logic                      off_pos;
    logic                      off_neg;
    logic                      delta_pos;
    logic                      far_ahead;
    logic                      in_window;
    logic                      bit_old;
    logic                      accept_next;
    logic [ROC_W-1:0]          guess;

    assign work_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || work_fire;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.accept       = out_accept_reg;
    assign out_ch.packet_index = out_index_reg;

    always_comb
    begin
        hs_eff    = seq_seen_reg ? highest_seq_reg : in_seq_reg;
        diff      = $signed(DIFF_W'(in_seq_reg)) - $signed(DIFF_W'(hs_eff));
        off_neg   = (hs_eff < SEQ_W'(srtp_rwc_pkg::HALF_SEQ))
                    && (diff > $signed(DIFF_W'(srtp_rwc_pkg::HALF_SEQ)));
        off_pos   = (hs_eff >= SEQ_W'(srtp_rwc_pkg::HALF_SEQ))
                    && ((hs_eff - SEQ_W'(srtp_rwc_pkg::HALF_SEQ)) > in_seq_reg);
        if (off_pos)
        begin
            delta = diff + $signed(DIFF_W'(srtp_rwc_pkg::SEQ_SPAN));
            guess = rollover_count_reg + ROC_W'(1);
        end
        else if (off_neg)
        begin
            delta = diff - $signed(DIFF_W'(srtp_rwc_pkg::SEQ_SPAN));
            guess = rollover_count_reg - ROC_W'(1);
        end
        else
        begin
            delta = diff;
            guess = rollover_count_reg;
        end
        neg_delta = -delta;
        delta_pos = !delta[DIFF_W-1] && (delta != '0);
        far_ahead = delta >= $signed(DIFF_W'(WINDOW_SIZE));
        in_window = neg_delta < $signed(DIFF_W'(WINDOW_SIZE));
        bit_old   = replay_bitmap_reg[neg_delta[IDX_W-1:0]];

        accept_next = !protection_enabled_reg || delta_pos || (in_window && !bit_old);

        replay_bitmap_next  = replay_bitmap_reg;
        highest_seq_next    = hs_eff;
        rollover_count_next = rollover_count_reg;
        if (in_op_reg == srtp_rwc_pkg::OP_UPDATE)
        begin
            if (delta_pos)
            begin
                if (far_ahead)
                    replay_bitmap_next = BIT0;
                else
                    replay_bitmap_next = (replay_bitmap_reg << delta[IDX_W-1:0]) | BIT0;
                if (in_seq_reg > hs_eff)
                    highest_seq_next = in_seq_reg;
            end
            else if (in_window)
            begin
                replay_bitmap_next = replay_bitmap_reg | (BIT0 << neg_delta[IDX_W-1:0]);
            end
            if (off_pos)
            begin
                rollover_count_next = guess;
                highest_seq_next    = in_seq_reg;
            end
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protection_enabled_reg <= 1'b1;
            rollover_count_reg     <= '0;
            highest_seq_reg        <= '0;
            seq_seen_reg           <= 1'b0;
            replay_bitmap_reg      <= '0;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                in_valid_reg <= 1'b1;
            else if (work_fire)
                in_valid_reg <= 1'b0;

            if (work_fire)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (work_fire)
            begin
                highest_seq_reg    <= highest_seq_next;
                seq_seen_reg       <= 1'b1;
                replay_bitmap_reg  <= replay_bitmap_next;
            end

            if (cfg_we && (cfg_index == srtp_rwc_pkg::REG_INITIAL_ROC))
                rollover_count_reg <= cfg_data;
            else if (work_fire)
                rollover_count_reg <= rollover_count_next;

            if (cfg_we && (cfg_index == srtp_rwc_pkg::REG_PROTECTION_ENABLED))
                protection_enabled_reg <= cfg_data[0];
        end
    end

    // beat payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_op_reg  <= in_ch.operation;
            in_seq_reg <= in_ch.seq_number;
        end
        if (work_fire)
        begin
            out_accept_reg <= accept_next;
            out_index_reg  <= {guess, in_seq_reg};
        end
    end

endmodule

FILE: hdl/srtp_rwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp replay window check checker
// port-level assertions on beat flow, bound to the top level
// ----------------------------------------------------------------------------
`include "srtp_replay_window_check_assert.svh"

module srtp_rwc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             out_accept,
    input logic [srtp_rwc_pkg::INDEX_W-1:0] out_packet_index
);

    // stalled result holds
    `SRTP_RWC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_accept) && $stable(out_packet_index), "result beat changed while stalled")

    // a fresh result follows an input beat that passed straight through the input register
    `SRTP_RWC_ASSERT_IMP(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result beat without matching input beat")

    // input back-pressure only from a stalled result
    `SRTP_RWC_ASSERT_IMP(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled with result side free")

endmodule

bind srtp_replay_window_check srtp_rwc_checker u_srtp_rwc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_accept       (out_ch.accept),
    .out_packet_index (out_ch.packet_index)
);

FILE: dv/srtp_replay_window_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtp replay window check testbench
// drives sequence beats through valid/ready with bursty sending and receiver
// stalls, predicts the packet index and the replay verdict of every beat from
// a local model of the counter, highest sequence and bitmap, and compares
// each result beat in order; directed cases cover the first packet, window
// edges, counter wrap both ways and disabled protection before random traffic
// ----------------------------------------------------------------------------
module srtp_replay_window_check_test;
    import srtp_rwc_pkg::*;

    localparam int   WINDOW       = DEFAULT_WINDOW_SIZE;
    localparam logic OP_CHECK     = 1'b0;
    localparam int   REPORT_LIMIT = 10;

    typedef struct packed {
        logic               accept;
        logic [INDEX_W-1:0] packet_index;
    } verdict_t;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    srtp_rwc_in_if  seq_ch ();
    srtp_rwc_out_if verdict_ch ();

    srtp_replay_window_check #(
        .WINDOW_SIZE(WINDOW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (seq_ch),
        .out_ch   (verdict_ch)
    );

    // window model
    logic [ROC_W-1:0]  model_roc;
    logic              model_protect;
    logic [SEQ_W-1:0]  model_top_seq;
    logic              model_seen;
    logic [WINDOW-1:0] model_bitmap;

    verdict_t pending_verdicts[$];
    verdict_t got_verdict;
    verdict_t want_verdict;
    int       failures = 0;

    rx_mode_t         rx_mode      = RX_FREE;
    bit               hold_request = 1'b0;
    int               hold_len     = 0;
    logic [SEQ_W-1:0] cursor       = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic verdict_t judge_packet(input logic op, input logic [SEQ_W-1:0] seq);
        verdict_t         v;
        int               offset;
        int               delta;
        int               back;
        logic [ROC_W-1:0] guess;
        if (!model_seen)
        begin
            model_seen    = 1'b1;
            model_top_seq = seq;
        end
        offset = 0;
        if (int'(model_top_seq) < HALF_SEQ)
        begin
            if (int'(seq) - int'(model_top_seq) > HALF_SEQ)
                offset = -1;
        end
        else if (int'(model_top_seq) - HALF_SEQ > int'(seq))
        begin
            offset = 1;
        end
        guess = model_roc + ROC_W'(offset);
        delta = offset * SEQ_SPAN + int'(seq) - int'(model_top_seq);
        back  = -delta;
        if (!model_protect || delta > 0)
            v.accept = 1'b1;
        else if (back >= WINDOW)
            v.accept = 1'b0;
        else
            v.accept = !model_bitmap[back];
        if (op == OP_UPDATE)
        begin
            if (delta > 0)
            begin
                if (delta >= WINDOW)
                    model_bitmap = '0;
                else
                    model_bitmap = model_bitmap << delta;
                model_bitmap[0] = 1'b1;
                if (seq > model_top_seq)
                    model_top_seq = seq;
            end
            else if (back < WINDOW)
            begin
                model_bitmap[back] = 1'b1;
            end
            if (offset == 1)
            begin
                model_roc     = guess;
                model_top_seq = seq;
            end
        end
        v.packet_index = {guess, seq};
        return v;
    endfunction

    // receiver stall pattern, with a long hold-off on request
    initial
    begin : rx_stall
        int hold_left;
        int tick;
        hold_left        = 0;
        tick             = 0;
        verdict_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                verdict_ch.ready = 1'b0;
            end
            else if (hold_request)
            begin
                hold_request     = 1'b0;
                hold_left        = hold_len - 1;
                verdict_ch.ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:    verdict_ch.ready = 1'b1;
                    RX_RANDOM:  verdict_ch.ready = ($urandom_range(0, 99) >= 30);
                    RX_PATTERN: verdict_ch.ready = ((tick % 7) != 3) && ((tick % 7) != 4);
                    default:    verdict_ch.ready = 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            got_verdict.accept       = verdict_ch.accept;
            got_verdict.packet_index = verdict_ch.packet_index;
            if (pending_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat: accept=%0b index=%012h",
                             got_verdict.accept, got_verdict.packet_index);
            end
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                if (got_verdict.accept !== want_verdict.accept ||
                    got_verdict.packet_index !== want_verdict.packet_index)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("mismatch: expected accept=%0b index=%012h, got accept=%0b index=%012h",
                                 want_verdict.accept, want_verdict.packet_index,
                                 got_verdict.accept, got_verdict.packet_index);
                end
            end
        end
    end

    task automatic send_packet(input logic op, input logic [SEQ_W-1:0] seq);
        @(negedge clk);
        seq_ch.valid      = 1'b1;
        seq_ch.operation  = op;
        seq_ch.seq_number = seq;
        @(posedge clk);
        while (!seq_ch.ready)
            @(posedge clk);
        pending_verdicts.insert(pending_verdicts.size(), judge_packet(op, seq));
    endtask

    task automatic idle_for(input int cycles);
        @(negedge clk);
        seq_ch.valid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic drain();
        idle_for(1);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_INITIAL_ROC)
            model_roc = data;
        else if (idx == REG_PROTECTION_ENABLED)
            model_protect = data[0];
    endtask

    // mostly in-order traffic with replays, reordering, jumps and noise
    task automatic send_random_packet();
        int               pick;
        logic             op;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(0, 99);
        op   = ($urandom_range(0, 3) != 0) ? OP_UPDATE : OP_CHECK;
        if (pick < 50)
        begin
            cursor = cursor + SEQ_W'($urandom_range(1, 3));
            seq    = cursor;
        end
        else if (pick < 68)
        begin
            seq = cursor - SEQ_W'($urandom_range(0, 140));
        end
        else if (pick < 78)
        begin
            seq = cursor;
        end
        else if (pick < 86)
        begin
            cursor = cursor + SEQ_W'($urandom_range(100, 40000));
            seq    = cursor;
        end
        else
        begin
            seq = SEQ_W'($urandom());
        end
        send_packet(op, seq);
    endtask

    task automatic run_traffic_phase(input logic [ROC_W-1:0] roc, input logic protect,
                                     input rx_mode_t mode, input bit gaps, input int items);
        int burst_left;
        drain();
        write_reg(REG_INITIAL_ROC, roc);
        write_reg(REG_PROTECTION_ENABLED, CFG_DATA_W'(protect));
        rx_mode    = mode;
        cursor     = SEQ_W'($urandom());
        burst_left = $urandom_range(1, 24);
        repeat (items)
        begin
            send_random_packet();
            burst_left--;
            if (burst_left == 0)
            begin
                if (gaps)
                    idle_for($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic test_first_packet();
        send_packet(OP_CHECK, 16'hFFFF);
        send_packet(OP_UPDATE, 16'hFFFF);
        send_packet(OP_CHECK, 16'hFFFF);
        send_packet(OP_UPDATE, 16'h0000);
        send_packet(OP_UPDATE, 16'hFFFF);
        send_packet(OP_UPDATE, 16'hFFFE);
    endtask

    task automatic test_window_edges();
        send_packet(OP_UPDATE, 16'd127);
        send_packet(OP_UPDATE, 16'd200);
        send_packet(OP_UPDATE, 16'd73);
        send_packet(OP_CHECK, 16'd73);
        send_packet(OP_UPDATE, 16'd72);
        send_packet(OP_UPDATE, 16'd328);
        send_packet(OP_CHECK, 16'd200);
        send_packet(OP_CHECK, 16'd201);
        send_packet(OP_CHECK, 16'd328);
    endtask

    task automatic test_counter_wrap();
        drain();
        write_reg(REG_INITIAL_ROC, 32'hFFFF_FFFF);
        send_packet(OP_UPDATE, 16'd40000);
        send_packet(OP_UPDATE, 16'd30000);
        send_packet(OP_UPDATE, 16'd60000);
        send_packet(OP_UPDATE, 16'd10);
        drain();
        write_reg(REG_INITIAL_ROC, 32'h0000_0000);
        send_packet(OP_UPDATE, 16'd65000);
        send_packet(OP_CHECK, 16'd10);
    endtask

    task automatic test_protection_disabled();
        drain();
        write_reg(REG_PROTECTION_ENABLED, 32'd0);
        send_packet(OP_CHECK, 16'd10);
        send_packet(OP_UPDATE, 16'd65000);
        send_packet(OP_UPDATE, 16'd11);
        drain();
        write_reg(REG_PROTECTION_ENABLED, 32'd1);
        send_packet(OP_CHECK, 16'd11);
    endtask

    task automatic test_backpressure();
        drain();
        rx_mode      = RX_FREE;
        hold_len     = 80;
        hold_request = 1'b1;
        repeat (40)
        begin
            cursor = cursor + 16'd1;
            send_packet(OP_UPDATE, cursor);
        end
        drain();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(32'h0000_0000, 1'b1, RX_RANDOM, 1'b1, 290);
        run_traffic_phase(32'hFFFF_FFFF, 1'b1, RX_PATTERN, 1'b1, 290);
        run_traffic_phase(ROC_W'($urandom()), 1'b0, RX_FREE, 1'b0, 290);
        run_traffic_phase(32'h7FFF_FFFF, 1'b1, RX_RANDOM, 1'b0, 290);
        run_traffic_phase(ROC_W'($urandom()), 1'b1, RX_FREE, 1'b1, 290);
        run_traffic_phase(32'h8000_0000, 1'b1, RX_PATTERN, 1'b1, 290);
        run_traffic_phase(32'h0000_0001, 1'b0, RX_RANDOM, 1'b1, 290);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_INITIAL_ROC;
        cfg_data          = '0;
        seq_ch.valid      = 1'b0;
        seq_ch.operation  = OP_CHECK;
        seq_ch.seq_number = '0;
        model_roc         = '0;
        model_protect     = 1'b1;
        model_top_seq     = '0;
        model_seen        = 1'b0;
        model_bitmap      = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_packet();
        test_window_edges();
        test_counter_wrap();
        test_protection_disabled();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (10)
            @(posedge clk);
        if (failures == 0)
            $display("[srtp_replay_window_check] OK");
        else
            $display("[srtp_replay_window_check] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[srtp_replay_window_check] ERROR");
        $finish;
    end

endmodule
